FILE: src/pnrf_pkg.sv
// Types, codes and register map tables shared by the paged register file.
package pnrf_pkg;

  typedef logic [5:0] slot_t;

  localparam int SlotW = 6;
  localparam int StoreDepth = 64;

  localparam logic [1:0] FUNC_READ  = 2'd0;
  localparam logic [1:0] FUNC_WRITE = 2'd1;
  localparam logic [1:0] FUNC_CORE  = 2'd2;

  localparam logic [3:0] CORE_BOUND  = 4'd0;
  localparam logic [3:0] CORE_RSAR   = 4'd1;
  localparam logic [3:0] CORE_PSTART = 4'd2;
  localparam logic [3:0] CORE_PSTOP  = 4'd3;
  localparam logic [3:0] CORE_TPSR   = 4'd4;
  localparam logic [3:0] CORE_TBCR   = 4'd5;
  localparam logic [3:0] CORE_CURR   = 4'd6;
  localparam logic [3:0] CORE_IMR    = 4'd7;
  localparam logic [3:0] CORE_TXP    = 4'd8;

  localparam logic [7:0] CMD_RESET   = 8'h04;
  localparam logic [7:0] RING_RESET  = 8'h46;
  localparam logic [7:0] STOP_RESET  = 8'h80;
  localparam logic [7:0] TXPG_RESET  = 8'h40;
  localparam logic [7:0] ISTAT_FORCE = 8'hff;

  localparam slot_t S_LDMA_LO  = 6'd0;
  localparam slot_t S_LDMA_HI  = 6'd1;
  localparam slot_t S_BOUND    = 6'd2;
  localparam slot_t S_TXSTAT   = 6'd3;
  localparam slot_t S_COLL     = 6'd4;
  localparam slot_t S_FIFO     = 6'd5;
  localparam slot_t S_ISTAT    = 6'd6;
  localparam slot_t S_RDMA_LO  = 6'd7;
  localparam slot_t S_RDMA_HI  = 6'd8;
  localparam slot_t S_IDENT_A  = 6'd9;
  localparam slot_t S_IDENT_B  = 6'd10;
  localparam slot_t S_RXSTAT   = 6'd11;
  localparam slot_t S_TALLY0   = 6'd12;
  localparam slot_t S_TALLY1   = 6'd13;
  localparam slot_t S_TALLY2   = 6'd14;
  localparam slot_t S_RSTART   = 6'd15;
  localparam slot_t S_RSTOP    = 6'd16;
  localparam slot_t S_TXPAGE   = 6'd17;
  localparam slot_t S_TXCNT_LO = 6'd18;
  localparam slot_t S_TXCNT_HI = 6'd19;
  localparam slot_t S_RSA_LO   = 6'd20;
  localparam slot_t S_RSA_HI   = 6'd21;
  localparam slot_t S_RBC_LO   = 6'd22;
  localparam slot_t S_RBC_HI   = 6'd23;
  localparam slot_t S_RXCFG    = 6'd24;
  localparam slot_t S_TXCFG    = 6'd25;
  localparam slot_t S_DCFG     = 6'd26;
  localparam slot_t S_IMASK    = 6'd27;
  localparam slot_t S_PHYS0    = 6'd28;
  localparam slot_t S_PHYS1    = 6'd29;
  localparam slot_t S_PHYS2    = 6'd30;
  localparam slot_t S_PHYS3    = 6'd31;
  localparam slot_t S_PHYS4    = 6'd32;
  localparam slot_t S_PHYS5    = 6'd33;
  localparam slot_t S_CURPG    = 6'd34;
  localparam slot_t S_MC0      = 6'd35;
  localparam slot_t S_MC1      = 6'd36;
  localparam slot_t S_MC2      = 6'd37;
  localparam slot_t S_MC3      = 6'd38;
  localparam slot_t S_MC4      = 6'd39;
  localparam slot_t S_MC5      = 6'd40;
  localparam slot_t S_MC6      = 6'd41;
  localparam slot_t S_MC7      = 6'd42;
  localparam slot_t S_EECMD    = 6'd43;
  localparam slot_t S_BOOTPG   = 6'd44;
  localparam slot_t S_CFG0     = 6'd45;
  localparam slot_t S_CFG1     = 6'd46;
  localparam slot_t S_CFG2     = 6'd47;
  localparam slot_t S_CFG3     = 6'd48;
  localparam slot_t S_CSN      = 6'd49;
  localparam slot_t S_INTPIN   = 6'd50;
  localparam slot_t S_CFG4     = 6'd51;
  localparam slot_t S_TESTR    = 6'd52;
  localparam slot_t S_HALTCLK  = 6'd53;
  localparam slot_t S_FLASHWP  = 6'd54;
  localparam slot_t S_CMD      = 6'd62;
  localparam slot_t S_NONE     = 6'd63;

  localparam slot_t READ_MAP [4][16] = '{
    '{S_CMD, S_LDMA_LO, S_LDMA_HI, S_BOUND, S_TXSTAT, S_COLL, S_FIFO, S_ISTAT,
      S_RDMA_LO, S_RDMA_HI, S_IDENT_A, S_IDENT_B, S_RXSTAT, S_TALLY0,
      S_TALLY1, S_TALLY2},
    '{S_CMD, S_PHYS0, S_PHYS1, S_PHYS2, S_PHYS3, S_PHYS4, S_PHYS5, S_CURPG,
      S_MC0, S_MC1, S_MC2, S_MC3, S_MC4, S_MC5, S_MC6, S_MC7},
    '{S_CMD, S_RSTART, S_RSTOP, S_NONE, S_TXPAGE, S_NONE, S_NONE, S_NONE,
      S_NONE, S_NONE, S_NONE, S_NONE, S_RXCFG, S_TXCFG, S_DCFG, S_IMASK},
    '{S_CMD, S_EECMD, S_BOOTPG, S_CFG0, S_CFG1, S_CFG2, S_CFG3, S_NONE,
      S_CSN, S_NONE, S_NONE, S_INTPIN, S_NONE, S_CFG4, S_NONE, S_NONE}
  };

  localparam slot_t WRITE_MAP [4][16] = '{
    '{S_CMD, S_RSTART, S_RSTOP, S_BOUND, S_TXPAGE, S_TXCNT_LO, S_TXCNT_HI,
      S_ISTAT, S_RSA_LO, S_RSA_HI, S_RBC_LO, S_RBC_HI, S_RXCFG, S_TXCFG,
      S_DCFG, S_IMASK},
    '{S_CMD, S_PHYS0, S_PHYS1, S_PHYS2, S_PHYS3, S_PHYS4, S_PHYS5, S_CURPG,
      S_MC0, S_MC1, S_MC2, S_MC3, S_MC4, S_MC5, S_MC6, S_MC7},
    '{S_CMD, S_RSTART, S_RSTOP, S_NONE, S_TXPAGE, S_NONE, S_NONE, S_NONE,
      S_NONE, S_NONE, S_NONE, S_NONE, S_RXCFG, S_TXCFG, S_DCFG, S_IMASK},
    '{S_CMD, S_EECMD, S_BOOTPG, S_NONE, S_CFG1, S_CFG2, S_CFG3, S_TESTR,
      S_NONE, S_HALTCLK, S_NONE, S_NONE, S_FLASHWP, S_NONE, S_NONE, S_NONE}
  };

  typedef struct packed {
    logic load;
    logic exec;
  } cmd_t;

  // True for registers held in flip-flops because they appear on every result.
  function automatic logic is_flop_slot(slot_t s);
    logic r;
    case (s)
      S_BOUND, S_CURPG, S_RSA_LO, S_RSA_HI, S_TXCNT_LO, S_TXCNT_HI,
      S_RSTART, S_RSTOP, S_TXPAGE, S_IMASK: r = 1'b1;
      default: r = 1'b0;
    endcase
    return r;
  endfunction

  function automatic logic is_ram_slot(slot_t s);
    return (s <= S_FLASHWP) && !is_flop_slot(s);
  endfunction

endpackage

FILE: src/pnrf_if.sv
// Request and response channel interfaces of the paged register file.
interface pnrf_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  func;
  logic [7:0]  address;
  logic [7:0]  wdata;
  logic [3:0]  core_reg;
  logic [15:0] core_value;

  modport source (output valid, func, address, wdata, core_reg, core_value,
                  input ready);
  modport sink (input valid, func, address, wdata, core_reg, core_value,
                output ready);
endinterface

interface pnrf_rsp_if;
  logic        valid;
  logic        ready;
  logic [7:0]  rdata;
  logic        bad_address;
  logic [1:0]  page;
  logic        txp;
  logic [7:0]  boundary;
  logic [7:0]  current_page;
  logic [15:0] remote_start;
  logic [15:0] tx_byte_count;
  logic [7:0]  ring_start;
  logic [7:0]  ring_stop;
  logic [7:0]  tx_start_page;
  logic [7:0]  irq_mask;

  modport source (output valid, rdata, bad_address, page, txp, boundary,
                  current_page, remote_start, tx_byte_count, ring_start,
                  ring_stop, tx_start_page, irq_mask,
                  input ready);
  modport sink (input valid, rdata, bad_address, page, txp, boundary,
                current_page, remote_start, tx_byte_count, ring_start,
                ring_stop, tx_start_page, irq_mask,
                output ready);
endinterface

FILE: src/pnrf_ram.sv
// Generic single-write, single-read RAM with registered read data.
module pnrf_ram #(
  parameter int Width = 8,
  parameter int Depth = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: src/pnrf_ctrl.sv
// Controller state machine that sequences one beat through the datapath.
module pnrf_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_ready,
  output logic              rsp_valid,
  input  logic              rsp_ready,
  output pnrf_pkg::cmd_t    cmd
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_READ = 2'd1;
  localparam logic [1:0] ST_EXEC = 2'd2;
  localparam logic [1:0] ST_OUT  = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (req_valid) state_next = ST_READ;
      ST_READ: state_next = ST_EXEC;
      ST_EXEC: state_next = ST_OUT;
      ST_OUT:  if (rsp_ready) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign req_ready = (state == ST_IDLE);
  assign rsp_valid = (state == ST_OUT);
  assign cmd.load  = (state == ST_IDLE) && req_valid;
  assign cmd.exec  = (state == ST_EXEC);

endmodule

FILE: src/pnrf_datapath.sv
// Datapath: beat capture, page decode, register flip-flops and the register RAM.
module pnrf_datapath (
  input  logic           clk,
  input  logic           rst,
  input  pnrf_pkg::cmd_t cmd,
  input  logic [1:0]     func,
  input  logic [7:0]     address,
  input  logic [7:0]     wdata,
  input  logic [3:0]     core_reg,
  input  logic [15:0]    core_value,
  output logic [7:0]     rdata,
  output logic           bad_address,
  output logic [1:0]     page,
  output logic           txp,
  output logic [7:0]     boundary,
  output logic [7:0]     current_page,
  output logic [15:0]    remote_start,
  output logic [15:0]    tx_byte_count,
  output logic [7:0]     ring_start,
  output logic [7:0]     ring_stop,
  output logic [7:0]     tx_start_page,
  output logic [7:0]     irq_mask
);

  logic [1:0]  func_q;
  logic [7:0]  addr_q;
  logic [7:0]  wdata_q;
  logic [3:0]  core_reg_q;
  logic [15:0] core_value_q;

  logic [7:0] command;
  logic [7:0] rsa_lo;
  logic [7:0] rsa_hi;
  logic [7:0] tbcr_lo;
  logic [7:0] tbcr_hi;
  logic [pnrf_pkg::StoreDepth-1:0] valid;

  logic            bad;
  logic            host_rd;
  logic            host_wr;
  logic            core_wr;
  pnrf_pkg::slot_t rslot;
  pnrf_pkg::slot_t wslot;
  logic [7:0]      ram_q;
  logic            ram_we;
  pnrf_pkg::slot_t ram_waddr;
  logic [7:0]      ram_wdata;
  logic [7:0]      rd_value;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      func_q       <= func;
      addr_q       <= address;
      wdata_q      <= wdata;
      core_reg_q   <= core_reg;
      core_value_q <= core_value;
    end
  end

  assign page    = command[7:6];
  assign txp     = command[2];
  assign bad     = (func_q == pnrf_pkg::FUNC_READ || func_q == pnrf_pkg::FUNC_WRITE)
                   && (addr_q[7:4] != 4'd0);
  assign host_rd = (func_q == pnrf_pkg::FUNC_READ) && !bad;
  assign host_wr = (func_q == pnrf_pkg::FUNC_WRITE) && !bad;
  assign core_wr = (func_q == pnrf_pkg::FUNC_CORE);
  assign rslot   = pnrf_pkg::READ_MAP[page][addr_q[3:0]];
  assign wslot   = pnrf_pkg::WRITE_MAP[page][addr_q[3:0]];

  // Reading the interrupt status register forces it to all ones; host writes to RAM-held slots store the write data.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = wslot;
    ram_wdata = wdata_q;
    if (cmd.exec) begin
      if (host_rd && rslot == pnrf_pkg::S_ISTAT) begin
        ram_we    = 1'b1;
        ram_waddr = pnrf_pkg::S_ISTAT;
        ram_wdata = pnrf_pkg::ISTAT_FORCE;
      end else if (host_wr && pnrf_pkg::is_ram_slot(wslot)) begin
        ram_we = 1'b1;
      end
    end
  end

  pnrf_ram #(
    .Width (8),
    .Depth (pnrf_pkg::StoreDepth)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (rslot),
    .rdata (ram_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (ram_we) begin
      valid[ram_waddr] <= 1'b1;
    end
  end

  always_comb begin
    case (rslot)
      pnrf_pkg::S_CMD:    rd_value = command;
      pnrf_pkg::S_NONE:   rd_value = 8'h00;
      pnrf_pkg::S_ISTAT:  rd_value = pnrf_pkg::ISTAT_FORCE;
      pnrf_pkg::S_BOUND:  rd_value = boundary;
      pnrf_pkg::S_CURPG:  rd_value = current_page;
      pnrf_pkg::S_RSTART: rd_value = ring_start;
      pnrf_pkg::S_RSTOP:  rd_value = ring_stop;
      pnrf_pkg::S_TXPAGE: rd_value = tx_start_page;
      pnrf_pkg::S_IMASK:  rd_value = irq_mask;
      default:            rd_value = valid[rslot] ? ram_q : 8'h00;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      rdata       <= host_rd ? rd_value : 8'h00;
      bad_address <= bad;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      command       <= pnrf_pkg::CMD_RESET;
      boundary      <= pnrf_pkg::RING_RESET;
      current_page  <= pnrf_pkg::RING_RESET;
      ring_start    <= pnrf_pkg::RING_RESET;
      ring_stop     <= pnrf_pkg::STOP_RESET;
      tx_start_page <= pnrf_pkg::TXPG_RESET;
      irq_mask      <= 8'h00;
      rsa_lo        <= 8'h00;
      rsa_hi        <= 8'h00;
      tbcr_lo       <= 8'h00;
      tbcr_hi       <= 8'h00;
    end else if (cmd.exec) begin
      if (host_wr) begin
        case (wslot)
          pnrf_pkg::S_CMD:      command       <= wdata_q;
          pnrf_pkg::S_BOUND:    boundary      <= wdata_q;
          pnrf_pkg::S_CURPG:    current_page  <= wdata_q;
          pnrf_pkg::S_RSTART:   ring_start    <= wdata_q;
          pnrf_pkg::S_RSTOP:    ring_stop     <= wdata_q;
          pnrf_pkg::S_TXPAGE:   tx_start_page <= wdata_q;
          pnrf_pkg::S_IMASK:    irq_mask      <= wdata_q;
          pnrf_pkg::S_RSA_LO:   rsa_lo        <= wdata_q;
          pnrf_pkg::S_RSA_HI:   rsa_hi        <= wdata_q;
          pnrf_pkg::S_TXCNT_LO: tbcr_lo       <= wdata_q;
          pnrf_pkg::S_TXCNT_HI: tbcr_hi       <= wdata_q;
          default: ;
        endcase
      end else if (core_wr) begin
        case (core_reg_q)
          pnrf_pkg::CORE_BOUND:  boundary      <= core_value_q[7:0];
          pnrf_pkg::CORE_RSAR: begin
            rsa_lo <= core_value_q[7:0];
            rsa_hi <= core_value_q[15:8];
          end
          pnrf_pkg::CORE_PSTART: ring_start    <= core_value_q[7:0];
          pnrf_pkg::CORE_PSTOP:  ring_stop     <= core_value_q[7:0];
          pnrf_pkg::CORE_TPSR:   tx_start_page <= core_value_q[7:0];
          pnrf_pkg::CORE_TBCR: begin
            tbcr_lo <= core_value_q[7:0];
            tbcr_hi <= core_value_q[15:8];
          end
          pnrf_pkg::CORE_CURR:   current_page  <= core_value_q[7:0];
          pnrf_pkg::CORE_IMR:    irq_mask      <= core_value_q[7:0];
          pnrf_pkg::CORE_TXP:    command[2]    <= core_value_q[0];
          default: ;
        endcase
      end
    end
  end

  assign remote_start  = {rsa_hi, rsa_lo};
  assign tx_byte_count = {tbcr_hi, tbcr_lo};

endmodule

FILE: src/paged_nic_register_file.sv
// Top level of the paged network controller register file.
// Each request beat on req is a host read, a host write or a core-side
// register write. Every request yields exactly one response beat on rsp,
// carrying the host read data, the bad address flag and the current
// core-side register values after the access.
// A request is taken only when the block is idle. It then passes through
// a read state, for the registered read of the register RAM, and an update
// state, which the response state follows.
// A new request is accepted in the cycle after the response beat is taken.
// Reset loads the documented register values at once and clears the
// written flags of the RAM, so no clearing pass is needed.
// When the receiver stalls, the response is held unchanged and no further
// request is accepted until it has been taken.
module paged_nic_register_file (
  input  logic clk,
  input  logic rst,
  pnrf_req_if.sink   req,
  pnrf_rsp_if.source rsp
);

  pnrf_pkg::cmd_t cmd;

  pnrf_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .cmd       (cmd)
  );

  pnrf_datapath u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .func          (req.func),
    .address       (req.address),
    .wdata         (req.wdata),
    .core_reg      (req.core_reg),
    .core_value    (req.core_value),
    .rdata         (rsp.rdata),
    .bad_address   (rsp.bad_address),
    .page          (rsp.page),
    .txp           (rsp.txp),
    .boundary      (rsp.boundary),
    .current_page  (rsp.current_page),
    .remote_start  (rsp.remote_start),
    .tx_byte_count (rsp.tx_byte_count),
    .ring_start    (rsp.ring_start),
    .ring_stop     (rsp.ring_stop),
    .tx_start_page (rsp.tx_start_page),
    .irq_mask      (rsp.irq_mask)
  );

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> !req.ready)
    else $error("request accepted while a response is pending");

  a_no_early_rsp: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready) |=> !rsp.valid)
    else $error("response valid directly after request accepted");

  a_bad_reads_zero: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.bad_address) |-> (rsp.rdata == 8'h00))
    else $error("bad address response carries read data");

  a_rsp_after_exec: assert property (@(posedge clk) disable iff (rst)
    cmd.exec |=> rsp.valid)
    else $error("update cycle not followed by a response");

endmodule
